// ===== rtl/core/crc8_checked_word_frame_parser_core_assert.svh =====
// Assertion macros used by the checker of the word frame parser.
`ifndef CRC8_CHECKED_WORD_FRAME_PARSER_CORE_ASSERT_SVH
`define CRC8_CHECKED_WORD_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, ignored during reset.
`define CWFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, ignored during reset.
`define CWFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/cwfp_pkg.sv =====
// Types, constants and the CRC-8 byte update of the word frame parser.
package cwfp_pkg;

   localparam int BYTE_W    = 8;
   localparam int POS_W     = 4;
   localparam int RAW_W     = 16;
   localparam int PRODUCT_W = 32;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [RAW_W-1:0]  raw_type;

   localparam byte_type CRC_INIT = 8'hFF;
   localparam byte_type CRC_POLY = 8'h31;

   // Index words that are reported divided by ten.
   localparam pos_type IDX_POS_A = 4'd6;
   localparam pos_type IDX_POS_B = 4'd7;
   localparam pos_type POS_MAX   = 4'hF;

   // floor(x / 10) == (x * 0xCCCD) >> 19 for every 16-bit x.
   localparam raw_type DIV10_RECIP = 16'hCCCD;
   localparam int      DIV10_SHIFT = 19;

   typedef struct packed {
      pos_type position;
      raw_type raw;
      logic    crc_ok;
      logic    frame_error;
      logic    last_word;
   } word_rec_type;

   // MSB-first CRC-8 over one byte, no reflection, no final XOR.
   function automatic byte_type crc8_update(input byte_type crc, input byte_type data);
      byte_type c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/cwfp_if.sv =====
// Channel interfaces: received bytes in, decoded words out.
interface cwfp_req_if import cwfp_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;
   logic     frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface cwfp_rsp_if import cwfp_pkg::*; ();
   logic    valid;
   logic    ready;
   pos_type word_position;
   raw_type raw_word;
   raw_type scaled_value;
   logic    crc_ok;
   logic    frame_error;
   logic    last_word;

   modport source (output valid, output word_position, output raw_word, output scaled_value,
                   output crc_ok, output frame_error, output last_word, input ready);
   modport sink   (input valid, input word_position, input raw_word, input scaled_value,
                   input crc_ok, input frame_error, input last_word, output ready);
   modport monitor (input valid, input ready, input word_position, input raw_word,
                    input scaled_value, input crc_ok, input frame_error, input last_word);
endinterface

// ===== rtl/core/cwfp_frame_track.sv =====
// Byte phase tracking, word assembly and CRC check, with a one-entry word register.
module cwfp_frame_track import cwfp_pkg::*; #(
   parameter int WORDS_PER_FRAME = 9
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  byte_type     rx_byte,
   input  logic         frame_start,
   output logic         rec_valid,
   input  logic         rec_pop,
   output word_rec_type rec
);

   localparam logic [1:0] PHASE_MSB = 2'd0;
   localparam logic [1:0] PHASE_LSB = 2'd1;
   localparam logic [1:0] PHASE_CRC = 2'd2;
   localparam pos_type    LAST_POS  = POS_W'(WORDS_PER_FRAME - 1);

   logic [1:0]   phase_ff, phase_in;
   pos_type      counter_ff, counter_in;
   byte_type     high_ff, high_in;
   byte_type     low_ff, low_in;
   byte_type     crc_ff, crc_in;
   logic         err_ff, err_in;
   logic         rec_valid_ff, rec_valid_in;
   word_rec_type rec_ff, rec_in;

   logic       take;
   logic [1:0] phase_cur;
   pos_type    counter_cur;
   logic       err_cur;
   logic       ok;
   logic       last;

   assign in_ready = !rec_valid_ff || rec_pop;
   assign take     = in_valid && in_ready;

   // A start mark drops any partial word before the byte is taken.
   assign phase_cur   = frame_start ? PHASE_MSB : phase_ff;
   assign counter_cur = frame_start ? '0 : counter_ff;
   assign err_cur     = frame_start ? 1'b0 : err_ff;

   assign ok   = (crc_ff == rx_byte);
   assign last = (counter_cur == LAST_POS);

   always_comb begin
      phase_in     = phase_ff;
      counter_in   = counter_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      crc_in       = crc_ff;
      err_in       = err_ff;
      rec_valid_in = rec_valid_ff && !rec_pop;
      rec_in       = rec_ff;
      if (take) begin
         counter_in = counter_cur;
         err_in     = err_cur;
         unique case (phase_cur)
            PHASE_LSB: begin
               low_in   = rx_byte;
               crc_in   = crc8_update(crc_ff, rx_byte);
               phase_in = PHASE_CRC;
            end
            PHASE_CRC: begin
               rec_in.position    = counter_cur;
               rec_in.raw         = {high_ff, low_ff};
               rec_in.crc_ok      = ok;
               rec_in.frame_error = err_cur || !ok;
               rec_in.last_word   = last;
               rec_valid_in       = 1'b1;
               phase_in           = PHASE_MSB;
               crc_in             = CRC_INIT;
               if (last || counter_cur == POS_MAX) begin
                  counter_in = '0;
                  err_in     = 1'b0;
               end else begin
                  counter_in = counter_cur + 1'b1;
                  err_in     = err_cur || !ok;
               end
            end
            default: begin
               // The unused phase code is handled as the MSB phase.
               high_in  = rx_byte;
               crc_in   = crc8_update(CRC_INIT, rx_byte);
               phase_in = PHASE_LSB;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_MSB;
         counter_ff   <= '0;
         crc_ff       <= CRC_INIT;
         err_ff       <= 1'b0;
         rec_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         counter_ff   <= counter_in;
         crc_ff       <= crc_in;
         err_ff       <= err_in;
         rec_valid_ff <= rec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff <= high_in;
      low_ff  <= low_in;
      rec_ff  <= rec_in;
   end

   assign rec_valid = rec_valid_ff;
   assign rec       = rec_ff;

endmodule

// ===== rtl/core/cwfp_scale_out.sv =====
// Divide-by-ten scaling of the index words and the result register.
module cwfp_scale_out import cwfp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         rec_valid,
   output logic         rec_pop,
   input  word_rec_type rec,
   output logic         out_valid,
   input  logic         out_ready,
   output word_rec_type out_rec,
   output raw_type      out_scaled
);

   logic                 out_valid_ff, out_valid_in;
   word_rec_type         out_rec_ff, out_rec_in;
   raw_type              scaled_ff, scaled_in;
   logic [PRODUCT_W-1:0] product;
   raw_type              quotient;

   assign rec_pop = rec_valid && (!out_valid_ff || out_ready);

   // Reciprocal multiply replaces the divide; exact over the whole 16-bit range.
   assign product  = PRODUCT_W'(rec.raw) * PRODUCT_W'(DIV10_RECIP);
   assign quotient = RAW_W'(product >> DIV10_SHIFT);

   always_comb begin
      out_valid_in = out_valid_ff && !out_ready;
      out_rec_in   = out_rec_ff;
      scaled_in    = scaled_ff;
      if (rec_pop) begin
         out_valid_in = 1'b1;
         out_rec_in   = rec;
         scaled_in    = (rec.position == IDX_POS_A || rec.position == IDX_POS_B)
                        ? quotient : rec.raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_rec_ff <= out_rec_in;
      scaled_ff  <= scaled_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_rec    = out_rec_ff;
   assign out_scaled = scaled_ff;

endmodule

// ===== rtl/core/crc8_checked_word_frame_parser_core.sv =====
// Top level of the CRC-8 checked word frame parser.
//
// The req channel carries one received response byte per transaction, with
// frame_start set on the first byte of a frame. Each word arrives as MSB,
// LSB and a CRC-8 byte (polynomial 0x31, initial value 0xFF). The rsp channel
// gives one transaction per word, on its CRC byte: position, raw word, value
// scaled by one tenth for the two index words, CRC pass, sticky frame error
// and last-word mark.
// Throughput is one byte per cycle while req_chan is ready; the CRC byte
// update is combinational. Once its CRC byte is accepted, a word is held
// in the word register and then in the result register, which takes the
// divide-by-ten multiply result, before it leaves on the rsp channel.
// Reset clears the byte phase, word counter and error flag, so the next byte
// is taken as the MSB of word 0, and empties both registers.
// When the receiver stalls, the result holds on the rsp channel; one more
// complete word can wait in the word register, and req drops ready for any
// byte while that register is full and cannot move on to the result register.
module crc8_checked_word_frame_parser_core import cwfp_pkg::*; #(
   parameter int WORDS_PER_FRAME = 9
) (
   input logic       clock,
   input logic       reset,
   cwfp_req_if.sink  req_chan,
   cwfp_rsp_if.source rsp_chan
);

   logic         rec_valid;
   logic         rec_pop;
   word_rec_type rec;
   logic         out_valid;
   word_rec_type out_rec;
   raw_type      out_scaled;

   cwfp_frame_track #(
      .WORDS_PER_FRAME(WORDS_PER_FRAME)
   ) u_frame_track (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .rx_byte     (req_chan.rx_byte),
      .frame_start (req_chan.frame_start),
      .rec_valid   (rec_valid),
      .rec_pop     (rec_pop),
      .rec         (rec)
   );

   cwfp_scale_out u_scale_out (
      .clock      (clock),
      .reset      (reset),
      .rec_valid  (rec_valid),
      .rec_pop    (rec_pop),
      .rec        (rec),
      .out_valid  (out_valid),
      .out_ready  (rsp_chan.ready),
      .out_rec    (out_rec),
      .out_scaled (out_scaled)
   );

   assign rsp_chan.valid         = out_valid;
   assign rsp_chan.word_position = out_rec.position;
   assign rsp_chan.raw_word      = out_rec.raw;
   assign rsp_chan.scaled_value  = out_scaled;
   assign rsp_chan.crc_ok        = out_rec.crc_ok;
   assign rsp_chan.frame_error   = out_rec.frame_error;
   assign rsp_chan.last_word     = out_rec.last_word;

endmodule

// ===== rtl/core/cwfp_checker.sv =====
// Port-level checker of the word frame parser and its bind to the top level.
`include "crc8_checked_word_frame_parser_core_assert.svh"

module cwfp_checker import cwfp_pkg::*; #(
   parameter int WORDS_PER_FRAME = 9
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input pos_type rsp_pos,
   input raw_type rsp_raw,
   input raw_type rsp_scaled,
   input logic    rsp_crc_ok,
   input logic    rsp_frame_error,
   input logic    rsp_last
);

   localparam pos_type LAST_POS = POS_W'(WORDS_PER_FRAME - 1);

   logic                     stalled;
   logic                     crc_fail;
   logic                     last_ok;
   logic                     plain_word;
   logic                     scale_ok;
   logic [POS_W+RAW_W-1:0]   word_id;

   assign stalled    = rsp_valid && !rsp_ready;
   assign crc_fail   = rsp_valid && !rsp_crc_ok;
   assign last_ok    = (rsp_last == (rsp_pos == LAST_POS)) && (rsp_pos <= LAST_POS);
   assign plain_word = rsp_valid && rsp_pos != IDX_POS_A && rsp_pos != IDX_POS_B;
   assign scale_ok   = (rsp_scaled == rsp_raw);
   assign word_id    = {rsp_pos, rsp_raw};

   // A stalled result transaction keeps its valid and its word.
   `CWFP_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(word_id), "stalled rsp changed")

   // A failed word always shows up in the sticky frame error.
   `CWFP_ASSERT_NOW(a_crc_sticky, crc_fail, rsp_frame_error, "CRC failure without frame error")

   // The last-word mark follows the position, and positions stay in the frame.
   `CWFP_ASSERT_NOW(a_last_pos, rsp_valid, last_ok, "last word mark does not match position")

   // Only the index words are scaled; all others pass the raw word through.
   `CWFP_ASSERT_NOW(a_scale_pass, plain_word, scale_ok, "non-index word was scaled")

endmodule

bind crc8_checked_word_frame_parser_core cwfp_checker #(
   .WORDS_PER_FRAME(WORDS_PER_FRAME)
) u_cwfp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_pos         (rsp_chan.word_position),
   .rsp_raw         (rsp_chan.raw_word),
   .rsp_scaled      (rsp_chan.scaled_value),
   .rsp_crc_ok      (rsp_chan.crc_ok),
   .rsp_frame_error (rsp_chan.frame_error),
   .rsp_last        (rsp_chan.last_word)
);

// ===== tb/crc8_checked_word_frame_parser_core_tb.sv =====
// Self-checking testbench of the CRC-8 checked word frame parser core.
`timescale 1ns / 100ps

module crc8_checked_word_frame_parser_core_tb;
   import cwfp_pkg::*;

   localparam int WORDS_PER_FRAME = 9;
   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 10;
   localparam int RANDOM_BYTES    = 700;

   typedef enum logic [1:0] {
      PHASE_MSB,
      PHASE_LSB,
      PHASE_CRC
   } byte_phase_type;

   typedef struct packed {
      pos_type position;
      raw_type raw;
      raw_type scaled;
      logic    crc_ok;
      logic    frame_error;
      logic    last_word;
   } decoded_word_type;

   logic clock;
   logic reset;

   cwfp_req_if req_chan ();
   cwfp_rsp_if rsp_chan ();

   crc8_checked_word_frame_parser_core #(
      .WORDS_PER_FRAME(WORDS_PER_FRAME)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Shadow state of the parser.
   byte_phase_type shadow_phase;
   pos_type        shadow_pos;
   byte_type       shadow_msb;
   byte_type       shadow_lsb;
   byte_type       shadow_crc;
   logic           shadow_error;

   decoded_word_type expected_words[$];
   int               error_count;
   int               bytes_sent;
   int               hold_request;
   bit               src_idle_en;
   bit               sink_idle_en;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic byte_type crc8_of(input byte_type crc, input byte_type data);
      byte_type acc;
      logic     feedback;
      acc = crc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         feedback = acc[BYTE_W-1] ^ data[i];
         acc = {acc[BYTE_W-2:0], 1'b0} ^ (feedback ? CRC_POLY : byte_type'(0));
      end
      return acc;
   endfunction

   // Mostly back to back, sometimes a few cycles, now and then a long gap.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic raw_type pick_raw();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return raw_type'($urandom);
   endfunction

   task automatic clear_shadow();
      shadow_phase = PHASE_MSB;
      shadow_pos   = '0;
      shadow_msb   = '0;
      shadow_lsb   = '0;
      shadow_crc   = CRC_INIT;
      shadow_error = 1'b0;
   endtask

   task automatic decode_byte(input byte_type data, input logic start);
      decoded_word_type word;
      if (start) begin
         shadow_phase = PHASE_MSB;
         shadow_pos   = '0;
         shadow_error = 1'b0;
         shadow_crc   = CRC_INIT;
      end
      if (shadow_phase == PHASE_LSB) begin
         shadow_lsb   = data;
         shadow_crc   = crc8_of(shadow_crc, data);
         shadow_phase = PHASE_CRC;
      end else if (shadow_phase != PHASE_CRC) begin
         shadow_msb   = data;
         shadow_crc   = crc8_of(CRC_INIT, data);
         shadow_phase = PHASE_LSB;
      end else begin
         word.position = shadow_pos;
         word.raw      = {shadow_msb, shadow_lsb};
         word.crc_ok   = (shadow_crc == data);
         if (!word.crc_ok) shadow_error = 1'b1;
         word.frame_error = shadow_error;
         if (shadow_pos == IDX_POS_A || shadow_pos == IDX_POS_B) begin
            word.scaled = word.raw / 16'd10;
         end else begin
            word.scaled = word.raw;
         end
         word.last_word = (shadow_pos == pos_type'(WORDS_PER_FRAME - 1));
         expected_words.push_back(word);
         shadow_phase = PHASE_MSB;
         shadow_crc   = CRC_INIT;
         if (word.last_word || shadow_pos == POS_MAX) begin
            shadow_pos   = '0;
            shadow_error = 1'b0;
         end else begin
            shadow_pos = shadow_pos + 1'b1;
         end
      end
   endtask

   // Valid stays high after a transaction; the next call lowers it only for a gap.
   task automatic send_byte(input byte_type data, input logic start);
      int gap;
      gap = src_idle_en ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.rx_byte     <= data;
      req_chan.frame_start <= start;
      do @(posedge clock); while (!req_chan.ready);
      decode_byte(data, start);
      bytes_sent++;
   endtask

   task automatic send_word(input raw_type value, input logic start, input logic corrupt);
      byte_type crc;
      crc = crc8_of(crc8_of(CRC_INIT, value[15:8]), value[7:0]);
      if (corrupt) crc = crc ^ byte_type'($urandom_range(1, 255));
      send_byte(value[15:8], start);
      send_byte(value[7:0], 1'b0);
      send_byte(crc, 1'b0);
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_word();
      decoded_word_type want;
      if (expected_words.size() == 0) begin
         report_mismatch("word with nothing expected", rsp_chan.word_position, 0);
      end else begin
         want = expected_words.pop_front();
         if (rsp_chan.word_position !== want.position)
            report_mismatch("word_position", rsp_chan.word_position, want.position);
         if (rsp_chan.raw_word !== want.raw)
            report_mismatch("raw_word", rsp_chan.raw_word, want.raw);
         if (rsp_chan.scaled_value !== want.scaled)
            report_mismatch("scaled_value", rsp_chan.scaled_value, want.scaled);
         if (rsp_chan.crc_ok !== want.crc_ok)
            report_mismatch("crc_ok", rsp_chan.crc_ok, want.crc_ok);
         if (rsp_chan.frame_error !== want.frame_error)
            report_mismatch("frame_error", rsp_chan.frame_error, want.frame_error);
         if (rsp_chan.last_word !== want.last_word)
            report_mismatch("last_word", rsp_chan.last_word, want.last_word);
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) check_word();
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (sink_idle_en && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("crc8_checked_word_frame_parser_core_tb: FAIL");
      $finish;
   end

   // One frame with extreme words, a bad CRC in the middle and both index words.
   task automatic test_full_frame();
      send_word(16'h0000, 1'b1, 1'b0);
      send_word(16'hFFFF, 1'b0, 1'b0);
      send_word(16'h1234, 1'b0, 1'b1);
      send_word(16'h8001, 1'b0, 1'b0);
      send_word(16'h7FFE, 1'b0, 1'b0);
      send_word(16'h00FF, 1'b0, 1'b0);
      send_word(16'hFFFF, 1'b0, 1'b0);
      send_word(16'h0009, 1'b0, 1'b0);
      send_word(16'h000A, 1'b0, 1'b0);
   endtask

   // After the last word the position wraps to zero and the error flag clears.
   task automatic test_wrap_without_start();
      send_word(16'hA55A, 1'b0, 1'b0);
   endtask

   // A start mark in the middle of a word drops the partial word.
   task automatic test_restart_mid_word();
      send_byte(8'hC3, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_word(16'h5AA5, 1'b1, 1'b0);
   endtask

   // The receiver holds off while the sender keeps offering, so req must stall.
   task automatic test_stall_fill();
      hold_request = HOLD_OFF_CYCLES;
      send_word(pick_raw(), 1'b1, 1'b0);
      for (int i = 1; i < 8; i++) send_word(pick_raw(), 1'b0, $urandom_range(0, 4) == 0);
   endtask

   // The sender goes idle until every expected transaction has come back.
   task automatic test_drain_pause();
      send_word(pick_raw(), 1'b1, 1'b0);
      send_word(pick_raw(), 1'b0, 1'b0);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      send_word(pick_raw(), 1'b0, 1'b1);
   endtask

   // Mostly well-formed frames with random content; some cut short, some noise.
   task automatic test_random_traffic();
      int target;
      int kind;
      int words;
      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         src_idle_en  = $urandom_range(0, 3) != 0;
         sink_idle_en = $urandom_range(0, 3) != 0;
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            send_word(pick_raw(), $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
            for (int i = 1; i < WORDS_PER_FRAME; i++)
               send_word(pick_raw(), 1'b0, $urandom_range(0, 9) == 0);
         end else if (kind < 85) begin
            words = $urandom_range(0, WORDS_PER_FRAME - 1);
            for (int i = 0; i < words; i++)
               send_word(pick_raw(), i == 0, $urandom_range(0, 9) == 0);
            for (int i = $urandom_range(0, 2); i > 0; i--)
               send_byte(byte_type'($urandom), words == 0);
         end else begin
            for (int i = $urandom_range(1, 12); i > 0; i--)
               send_byte(byte_type'($urandom), $urandom_range(0, 3) == 0);
         end
      end
      src_idle_en  = 1'b1;
      sink_idle_en = 1'b1;
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.rx_byte     = '0;
      req_chan.frame_start = 1'b0;
      error_count          = 0;
      bytes_sent           = 0;
      hold_request         = 0;
      src_idle_en          = 1'b1;
      sink_idle_en         = 1'b1;
      clear_shadow();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_full_frame();
      test_wrap_without_start();
      test_restart_mid_word();
      test_stall_fill();
      test_drain_pause();
      test_random_traffic();

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("crc8_checked_word_frame_parser_core_tb: PASS");
      end else begin
         $display("crc8_checked_word_frame_parser_core_tb: FAIL");
      end
      $finish;
   end

endmodule
